>>> sv/itrt_pkg.sv
// ============================================================================
// itrt_pkg
// Shared types and constants for the integer to radix text converter.
// ============================================================================
package itrt_pkg;

    // Largest number of digits any argument can produce (64-bit octal).
    localparam int MAX_DIGITS = 22;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;

    // Decimal division walks the magnitude in 16-bit chunks.
    localparam int CHUNK_W     = 16;
    localparam int STEP_W      = $clog2(VALUE_W / CHUNK_W);
    localparam int DEC_X_W     = DIGIT_W + CHUNK_W;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = DEC_X_W + RECIP_W;

    // Rounded-up 2^23 / 10; exact for every chunk dividend below 2^22.
    localparam logic [RECIP_W-1:0] RECIP_10  = 20'd838861;
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(VALUE_W / CHUNK_W - 1);

    // Width mode codes.
    localparam logic [1:0] WIDTH_16 = 2'd0;
    localparam logic [1:0] WIDTH_32 = 2'd1;
    localparam logic [1:0] WIDTH_64 = 2'd2;

    // Radix selector codes.
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_sign;
        logic emit_digit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic mag_zero;
        logic negative;
        logic cnt_one;
        logic out_free;
    } dp_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {3'd0, d};
        end
        else
        begin
            c = CHAR_LOWER_A + {3'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

>>> sv/itrt_datapath.sv
// ============================================================================
// itrt_datapath
// Magnitude register, divider by the radix, digit buffer and output
// register.
// ============================================================================
module itrt_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  itrt_pkg::ctrl_cmd_t     cmd,
    output itrt_pkg::dp_status_t    status,
    input  logic [63:0]             value,
    input  logic [1:0]              width_mode,
    input  logic                    is_signed,
    input  logic [1:0]              radix_sel,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [6:0]              out_char,
    output logic                    out_last
);
    import itrt_pkg::*;

    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [1:0]          rsel_reg, rsel_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]  digit_mem [MAX_DIGITS];
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_last_reg;

    logic [VALUE_W-1:0]  mask;
    logic [VALUE_W-1:0]  sign_bit;
    logic [VALUE_W-1:0]  masked;
    logic                sgn;
    logic [DEC_X_W-1:0]  dec_x;
    logic [PROD_W-1:0]   dec_prod;
    logic [CHUNK_W-1:0]  dec_q;
    logic [DEC_X_W-1:0]  dec_q10;
    logic [CNT_W-1:0]    rd_idx;

    always_comb
    begin
        case (width_mode)
            WIDTH_16:
            begin
                mask     = 64'h0000_0000_0000_ffff;
                sign_bit = 64'h0000_0000_0000_8000;
            end
            WIDTH_32:
            begin
                mask     = 64'h0000_0000_ffff_ffff;
                sign_bit = 64'h0000_0000_8000_0000;
            end
            default:
            begin
                mask     = 64'hffff_ffff_ffff_ffff;
                sign_bit = 64'h8000_0000_0000_0000;
            end
        endcase
        masked = value & mask;
        // Octal is always printed unsigned.
        sgn = is_signed && (radix_sel != RADIX_OCT);
    end

    // Division by ten takes the top chunk with the running remainder, divides it
    // by a reciprocal multiply and rotates the chunk quotient in at the bottom.
    // After four steps the magnitude holds the full quotient.
    assign dec_x    = {rem_reg, mag_reg[VALUE_W-1 -: CHUNK_W]};
    assign dec_prod = PROD_W'(dec_x) * PROD_W'(RECIP_10);
    assign dec_q    = dec_prod[RECIP_SHIFT +: CHUNK_W];
    assign dec_q10  = DEC_X_W'({dec_q, 3'b000}) + DEC_X_W'({dec_q, 1'b0});
    assign rd_idx   = cnt_reg - 1'b1;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        rsel_next = rsel_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            case (radix_sel)
                RADIX_OCT: rsel_next = RADIX_OCT;
                RADIX_DEC: rsel_next = RADIX_DEC;
                default:   rsel_next = RADIX_HEX;
            endcase
            if (sgn && ((masked & sign_bit) != '0))
            begin
                neg_next = 1'b1;
                mag_next = ((~masked) + 64'd1) & mask;
            end
            else
            begin
                neg_next = 1'b0;
                mag_next = masked;
            end
            rem_next  = '0;
            step_next = '0;
            cnt_next  = '0;
        end
        else if (cmd.div_step)
        begin
            case (rsel_reg)
                RADIX_OCT:
                begin
                    mag_next = {3'd0, mag_reg[VALUE_W-1:3]};
                    rem_next = {1'b0, mag_reg[2:0]};
                end
                RADIX_DEC:
                begin
                    mag_next  = {mag_reg[VALUE_W-CHUNK_W-1:0], dec_q};
                    rem_next  = DIGIT_W'(dec_x - dec_q10);
                    step_next = step_reg + 1'b1;
                end
                default:
                begin
                    mag_next = {4'd0, mag_reg[VALUE_W-1:4]};
                    rem_next = mag_reg[3:0];
                end
            endcase
        end
        else if (cmd.store)
        begin
            cnt_next  = cnt_reg + 1'b1;
            rem_next  = '0;
            step_next = '0;
        end
        else if (cmd.emit_digit)
        begin
            cnt_next = rd_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        rsel_reg <= rsel_next;
        neg_reg  <= neg_next;
        if (cmd.store)
        begin
            digit_mem[cnt_reg] <= rem_reg;
        end
        if (cmd.emit_sign)
        begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_char_reg <= digit_char(digit_mem[rd_idx]);
            out_last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

    always_comb
    begin
        if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Octal and hex finish a digit in one step, decimal in four.
    assign status.div_last = (rsel_reg != RADIX_DEC) || (step_reg == LAST_STEP);
    assign status.mag_zero = (mag_reg == '0);
    assign status.negative = neg_reg;
    assign status.cnt_one  = (cnt_reg == CNT_W'(1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

>>> sv/itrt_ctrl.sv
// ============================================================================
// itrt_ctrl
// Sequencer for load, digit division, digit store and character emission.
// ============================================================================
module itrt_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  itrt_pkg::dp_status_t    status,
    output itrt_pkg::ctrl_cmd_t     cmd
);
    import itrt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // The magnitude now holds the quotient of the digit just finished.
                if (!status.mag_zero)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (status.negative)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.cnt_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.out_free;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/integer_to_radix_text_core.sv
// Each digit takes one divide step and a store for octal and hex, and four
// divide steps and a store for decimal; the characters, led by a minus sign
// for a negative value, follow once every digit is stored. A new number is
// accepted only once the last character of the previous one has entered the
// output register.
// Reset is asynchronous and active low; it idles the sequencer and clears valid.
// ============================================================================
// integer_to_radix_text_core
// Converts one integer argument to ASCII digits in octal, decimal or hex.
// ============================================================================
module integer_to_radix_text_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [4:0]  s_tuser,   // [1:0] width_mode, [2] is_signed, [4:3] radix_sel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast    // last_char
);
    import itrt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [6:0] char_code;

    itrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itrt_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .value      (s_tdata),
        .width_mode (s_tuser[1:0]),
        .is_signed  (s_tuser[2]),
        .radix_sel  (s_tuser[4:3]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (char_code),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, char_code};

endmodule

>>> sv/itrt_checker.sv
// ============================================================================
// itrt_checker
// Port-level checks for the integer to radix text converter.
// ============================================================================
module itrt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // A stalled output transfer holds its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Accepting a number starts a conversion, so the input closes after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted number");

    // While a non-final character is pending the number is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("idle while a number is only partly sent");

    // Only digits, lowercase hex letters or the minus sign are ever sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= 8'h30 && m_tdata <= 8'h39)
                  || (m_tdata >= 8'h61 && m_tdata <= 8'h66)
                  || (m_tdata == 8'h2d))
        else $error("illegal character code");

endmodule

bind integer_to_radix_text_core itrt_checker u_itrt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> dv/integer_to_radix_text_core_test.sv
// ============================================================================
// integer_to_radix_text_core_test
// Self-checking testbench for the integer to radix text converter. Integer
// arguments are streamed in with random gaps, the expected character stream
// of each one is computed on transfer, and every character that comes out
// is compared with the oldest outstanding expectation.
// ============================================================================
module integer_to_radix_text_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import itrt_pkg::*;

    localparam int NUM_RANDOM     = 160;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct {
        logic [63:0] value;
        logic [4:0]  user;
    } int_arg_t;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int_arg_t   pending_args[$];
    text_char_t expected_chars[$];
    string      digit_set = "0123456789abcdef";

    int  args_accepted = 0;
    int  arg_total     = 0;
    int  fail_count    = 0;
    int  quiet_cycles  = 0;
    int  src_wait      = 0;
    int  sink_wait     = 0;
    bit  src_burst     = 1'b0;
    bit  sink_burst    = 1'b0;
    bit  sink_hold     = 1'b0;
    bit  in_xfer       = 1'b0;
    bit  out_xfer      = 1'b0;

    integer_to_radix_text_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic add_arg(input logic [63:0] value, input logic [1:0] mode,
                           input logic sgn, input logic [1:0] rsel);
        int_arg_t a;
        a.value = value;
        a.user  = {rsel, sgn, mode};
        pending_args.push_back(a);
    endtask

    // Builds the character stream for one argument, most significant first.
    function automatic void predict_text(input logic [63:0] raw, input logic [4:0] user);
        logic [1:0]  mode;
        logic        sgn;
        logic [1:0]  rsel;
        logic [63:0] radix;
        logic [63:0] mask;
        logic [63:0] sign_bit;
        logic [63:0] mag;
        logic        negative;
        logic [6:0]  text[$];
        text_char_t  c;
        byte         ch;
        mode     = user[1:0];
        sgn      = user[2];
        rsel     = user[4:3];
        negative = 1'b0;
        if (rsel == RADIX_OCT)
        begin
            radix = 64'd8;
            sgn   = 1'b0;
        end
        else if (rsel == RADIX_DEC)
        begin
            radix = 64'd10;
        end
        else
        begin
            radix = 64'd16;
        end
        if (mode == WIDTH_16)
        begin
            mask     = 64'h0000_0000_0000_ffff;
            sign_bit = 64'h0000_0000_0000_8000;
        end
        else if (mode == WIDTH_32)
        begin
            mask     = 64'h0000_0000_ffff_ffff;
            sign_bit = 64'h0000_0000_8000_0000;
        end
        else
        begin
            mask     = 64'hffff_ffff_ffff_ffff;
            sign_bit = 64'h8000_0000_0000_0000;
        end
        mag = raw & mask;
        if (sgn && (mag & sign_bit) != 64'd0)
        begin
            negative = 1'b1;
            mag      = (~mag + 64'd1) & mask;
        end
        do
        begin
            ch = digit_set[int'(mag % radix)];
            text.push_front(ch[6:0]);
            mag = mag / radix;
        end
        while (mag != 64'd0);
        if (negative)
        begin
            text.push_front(CHAR_MINUS);
        end
        foreach (text[i])
        begin
            c.code = text[i];
            c.last = (i == text.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // Transfer bookkeeping, prediction, checking and the watchdog.
    always @(posedge clk)
    begin
        text_char_t want;
        in_xfer  = rst_n && s_tvalid && s_tready;
        out_xfer = rst_n && m_tvalid && m_tready;
        if (in_xfer)
        begin
            predict_text(s_tdata, s_tuser);
            args_accepted++;
        end
        if (out_xfer)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character data 0x%02h last %0b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata !== {1'b0, want.code})
                begin
                    report_mismatch($sformatf("char_code got 0x%02h expected 0x%02h",
                                              m_tdata, {1'b0, want.code}));
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch($sformatf("last_char got %0b expected %0b",
                                              m_tlast, want.last));
                end
            end
        end
        if (in_xfer || out_xfer)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Argument driver: each argument waits a random number of cycles unless
    // a burst stretch is running.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_xfer))
        begin
            if (in_xfer)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    src_burst = !src_burst;
                end
                src_wait = src_burst ? 0 : $urandom_range(0, 10);
            end
            if (src_wait > 0)
            begin
                src_wait--;
                s_tvalid <= 1'b0;
            end
            else if (pending_args.size() > 0)
            begin
                s_tdata  <= pending_args[0].value;
                s_tuser  <= pending_args[0].user;
                s_tvalid <= 1'b1;
                void'(pending_args.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Character sink with random back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_xfer)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    sink_burst = !sink_burst;
                end
                sink_wait = sink_burst ? 0 : $urandom_range(0, 10);
            end
            if (sink_hold)
            begin
                m_tready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // One long receiver stall while arguments keep coming, so that the
    // converter backs up and drops s_tready.
    initial
    begin
        wait (args_accepted >= 40);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin
        logic [63:0] v;
        logic [1:0]  mode;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 64'd0;
        s_tuser  = 5'd0;
        m_tready = 1'b0;

        // Zero in each radix, with a different width for each.
        add_arg(64'd0, WIDTH_16, 1'b1, RADIX_OCT);
        add_arg(64'd0, WIDTH_32, 1'b1, RADIX_DEC);
        add_arg(64'd0, WIDTH_64, 1'b0, RADIX_HEX);
        // Bits above the selected width are ignored.
        add_arg(64'hffff_ffff_ffff_0000, WIDTH_16, 1'b0, RADIX_DEC);
        add_arg(64'h1234_5678_0000_7fff, WIDTH_16, 1'b1, RADIX_DEC);
        // Most negative values take their full magnitude.
        add_arg(64'h0000_0000_0000_8000, WIDTH_16, 1'b1, RADIX_DEC);
        add_arg(64'h0000_0000_0000_8000, WIDTH_16, 1'b1, RADIX_HEX);
        add_arg(64'h0000_0000_8000_0000, WIDTH_32, 1'b1, RADIX_DEC);
        add_arg(64'h8000_0000_0000_0000, WIDTH_64, 1'b1, RADIX_DEC);
        add_arg(64'h8000_0000_0000_0000, WIDTH_64, 1'b1, RADIX_HEX);
        // Minus one signed and all ones unsigned.
        add_arg(64'h0000_0000_0000_ffff, WIDTH_16, 1'b1, RADIX_DEC);
        add_arg(64'h0000_0000_ffff_ffff, WIDTH_32, 1'b1, RADIX_HEX);
        add_arg(64'hffff_ffff_ffff_ffff, WIDTH_64, 1'b1, RADIX_DEC);
        add_arg(64'hffff_ffff_ffff_ffff, WIDTH_64, 1'b0, RADIX_OCT);
        add_arg(64'hffff_ffff_ffff_ffff, WIDTH_64, 1'b0, RADIX_DEC);
        add_arg(64'hffff_ffff_ffff_ffff, WIDTH_64, 1'b0, RADIX_HEX);
        // Octal ignores the signed flag; the 64-bit case gives the longest text.
        add_arg(64'h8000_0000_0000_0000, WIDTH_64, 1'b1, RADIX_OCT);
        add_arg(64'h0000_0000_0000_8000, WIDTH_16, 1'b1, RADIX_OCT);
        // Width mode three acts as 64-bit, radix selector three as hex.
        add_arg(64'hfedc_ba98_7654_3210, 2'd3, 1'b1, RADIX_DEC);
        add_arg(64'h0123_4567_89ab_cdef, WIDTH_32, 1'b0, 2'd3);
        add_arg(64'h8000_0000_0000_0001, 2'd3, 1'b1, 2'd3);
        add_arg(64'h0000_0000_7fff_ffff, WIDTH_32, 1'b1, RADIX_DEC);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1:    v = 64'($urandom_range(0, 20));
                2:
                begin
                    case ($urandom_range(0, 6))
                        0:       v = 64'h0000_0000_0000_8000;
                        1:       v = 64'h0000_0000_0000_ffff;
                        2:       v = 64'h0000_0000_0000_7fff;
                        3:       v = 64'h0000_0000_8000_0000;
                        4:       v = 64'h0000_0000_ffff_ffff;
                        5:       v = 64'h8000_0000_0000_0000;
                        default: v = 64'hffff_ffff_ffff_ffff;
                    endcase
                end
                3:       v = -{32'd0, $urandom_range(1, 200)};
                default: v = {$urandom, $urandom};
            endcase
            add_arg(v, mode, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        end
        arg_total = pending_args.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (args_accepted == arg_total);
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_chars.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
sv/itrt_pkg.sv
sv/itrt_datapath.sv
sv/itrt_ctrl.sv
sv/integer_to_radix_text_core.sv
sv/itrt_checker.sv
dv/integer_to_radix_text_core_test.sv
